// ===== hdl/sfmt_pkg.sv =====
// Shared types and constants for the 8.3 short-name formatter.
`timescale 1ns / 1ps
`default_nettype none
package sfmt_pkg;

  localparam int FMT_LEN  = 11;
  localparam int BASE_LEN = 8;
  localparam int EXT_LEN  = 3;
  localparam int IDX_W    = 4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] DEL_MARK  = 8'hE5;

  typedef struct packed {
    logic [7:0] name_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       status;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic       bad;
    logic       dot;
    logic       del;
    logic [7:0] up;
  } chk_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_SKIP,
    PH_EXT
  } phase_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/short_name_formatter_top.sv =====
// Top level of the 8.3 short-name formatter.
// Takes a file name one byte per cycle on the in_ channel, with last_char set on
// the final byte. Each byte is checked and upper-cased by a single check unit, and
// bytes kept for the name are stored through a single buffer write port. After the
// final byte the block stops taking input and drains the result through the
// buffer's one read port: eleven items for a valid name (8 base bytes, 3 extension
// bytes, space padded, last_out on the eleventh) or one item with status 1 and
// out_char 0 for an invalid name. State is cleared after every name; no setup is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module short_name_formatter_top
  import sfmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  chk_t             chk;
  buf_wr_t          wr;
  logic             clr;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  sfmt_chk u_chk (
    .ch  (in_data.name_char),
    .res (chk)
  );

  sfmt_buf u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .clr     (clr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfmt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .chk       (chk),
    .wr        (wr),
    .clr       (clr),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.last_out && (out_data.out_char == 8'h00)))
    else $error("error result not a single zero item");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_char) |=> out_valid)
    else $error("final byte did not start a drain");

  a_back_to_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_out) |=> (in_ready && !out_valid))
    else $error("block did not return to input after the final result");
`endif

endmodule
`default_nettype wire

// ===== hdl/sfmt_chk.sv =====
// Character check and upper-case unit shared by base and extension bytes.
`timescale 1ns / 1ps
`default_nettype none
module sfmt_chk
  import sfmt_pkg::*;
(
  input  wire logic [7:0] ch,
  output chk_t            res
);

  always_comb begin
    res.bad = (ch <= CH_SPACE) || (ch == CH_COLON) || (ch == CH_BSLASH);
    res.dot = (ch == CH_DOT);
    res.del = (ch == DEL_MARK);
    if ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) begin
      res.up = ch - CH_CASE;
    end else begin
      res.up = ch;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sfmt_buf.sv =====
// Eleven-byte name buffer with per-entry valid bits; empty entries read as space.
`timescale 1ns / 1ps
`default_nettype none
module sfmt_buf
  import sfmt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire buf_wr_t          wr,
  input  wire logic             clr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0]         data_r [FMT_LEN];
  logic [FMT_LEN-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      data_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data = vld_r[rd_addr] ? data_r[rd_addr] : CH_SPACE;
  end

endmodule
`default_nettype wire

// ===== hdl/sfmt_seq.sv =====
// Sequencer: per-byte name parsing and the drain of the formatted name.
`timescale 1ns / 1ps
`default_nettype none
module sfmt_seq
  import sfmt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire chk_t             chk,
  output buf_wr_t               wr,
  output logic                  clr,
  output logic      [IDX_W-1:0] rd_addr,
  input  wire logic [7:0]       rd_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FMT_LEN - 1);
  localparam logic [IDX_W-1:0] BASE_END = IDX_W'(BASE_LEN);
  localparam logic [1:0]       EXT_END  = 2'(EXT_LEN);

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [1:0]       ext_r, ext_nxt;
  logic [1:0]       seen_r, seen_nxt;
  logic             lead_r, lead_nxt;
  logic             dbl_r, dbl_nxt;
  logic             err_r, err_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             fin_err;
  logic             in_acc;
  logic             out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      phase_r <= PH_BASE;
      base_r  <= '0;
      ext_r   <= '0;
      seen_r  <= '0;
      lead_r  <= 1'b0;
      dbl_r   <= 1'b0;
      err_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      ext_r   <= ext_nxt;
      seen_r  <= seen_nxt;
      lead_r  <= lead_nxt;
      dbl_r   <= dbl_nxt;
      err_r   <= err_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    in_ready  = (state_r == ST_COLLECT);
    out_valid = (state_r == ST_DRAIN);
    in_acc    = in_valid && in_ready;
    out_acc   = out_valid && out_ready;
    rd_addr   = idx_r;
    clr       = 1'b0;

    state_nxt = state_r;
    phase_nxt = phase_r;
    base_nxt  = base_r;
    ext_nxt   = ext_r;
    seen_nxt  = seen_r;
    lead_nxt  = lead_r;
    dbl_nxt   = dbl_r;
    err_nxt   = err_r;
    idx_nxt   = idx_r;
    fin_err   = 1'b0;

    wr.en   = 1'b0;
    wr.addr = base_r;
    wr.data = chk.up;

    out_data.status   = err_r;
    out_data.last_out = err_r || (idx_r == LAST_IDX);
    if (err_r) begin
      out_data.out_char = '0;
    end else if (lead_r && (idx_r == '0)) begin
      out_data.out_char = CH_DOT;
    end else if (lead_r && dbl_r && (idx_r == IDX_W'(1))) begin
      out_data.out_char = CH_DOT;
    end else begin
      out_data.out_char = rd_data;
    end

    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (!err_r) begin
            if (seen_r == '0) begin
              if (chk.del) begin
                err_nxt = 1'b1;
              end else if (chk.dot) begin
                lead_nxt = 1'b1;
              end else if (chk.bad) begin
                err_nxt = 1'b1;
              end else begin
                wr.en    = 1'b1;
                base_nxt = base_r + IDX_W'(1);
              end
            end else if (lead_r) begin
              if ((seen_r == 2'd1) && chk.dot) begin
                dbl_nxt = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end else begin
              unique case (phase_r)
                PH_BASE: begin
                  if (chk.bad) begin
                    err_nxt = 1'b1;
                  end else if (chk.dot) begin
                    phase_nxt = PH_EXT;
                  end else if (base_r < BASE_END) begin
                    wr.en    = 1'b1;
                    base_nxt = base_r + IDX_W'(1);
                    if (base_nxt >= BASE_END) begin
                      phase_nxt = PH_SKIP;
                    end
                  end
                end
                PH_SKIP: begin
                  if (chk.dot) begin
                    phase_nxt = PH_EXT;
                  end
                end
                PH_EXT: begin
                  if (ext_r < EXT_END) begin
                    if (chk.bad || chk.dot) begin
                      err_nxt = 1'b1;
                    end else begin
                      wr.en   = 1'b1;
                      wr.addr = BASE_END + {{(IDX_W-2){1'b0}}, ext_r};
                      ext_nxt = ext_r + 2'd1;
                    end
                  end
                end
                default: begin
                  err_nxt = err_r;
                end
              endcase
            end
          end
          if (seen_r != 2'd3) begin
            seen_nxt = seen_r + 2'd1;
          end
          if (in_data.last_char) begin
            fin_err   = err_nxt || (!lead_nxt && (base_nxt == '0));
            err_nxt   = fin_err;
            state_nxt = ST_DRAIN;
            idx_nxt   = '0;
            phase_nxt = PH_BASE;
            base_nxt  = '0;
            ext_nxt   = '0;
            seen_nxt  = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          if (out_data.last_out) begin
            clr       = 1'b1;
            state_nxt = ST_COLLECT;
            lead_nxt  = 1'b0;
            dbl_nxt   = 1'b0;
            err_nxt   = 1'b0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== tb/sv/short_name_formatter_top_tb.sv =====
// Self-checking testbench for the 8.3 short-name formatter: byte stream in, formatted name out.
`timescale 1ns / 1ps
module short_name_formatter_top_tb;
  import sfmt_pkg::*;

  typedef struct packed {
    in_item_t item;
    logic     hold_idle;
  } queued_byte_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queued_byte_t name_bytes_q[$];
  out_item_t    dir_name_q[$];
  logic [7:0]   scratch[$];

  phase_t     ph;
  logic [7:0] name_buf [FMT_LEN];
  int         base_cnt;
  int         ext_cnt;
  int         seen_cnt;
  logic       lead_dot;
  logic       dot_dot;
  logic       err_flag;

  logic        in_fire = 1'b0;
  logic [31:0] cyc_cnt = '0;
  logic        quiet;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_cnt = 0;
  int          mismatches = 0;
  int          names_ok = 0;
  int          names_bad = 0;
  int          bytes_in = 0;
  int          results_seen = 0;

  assign quiet = (cyc_cnt[8:7] == 2'b01);

  short_name_formatter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic is_bad(logic [7:0] c);
    return (c <= CH_SPACE) || (c == CH_COLON) || (c == CH_BSLASH);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CH_CASE : c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] good_char();
    logic [7:0] c;
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
    do c = 8'($urandom_range(33, 255));
    while (c == CH_COLON || c == CH_BSLASH || c == CH_DOT);
    return c;
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 32));
      1: return CH_COLON;
      2: return CH_BSLASH;
      default: return CH_DOT;
    endcase
  endfunction

  task clear_name_state();
    ph = PH_BASE;
    for (int k = 0; k < FMT_LEN; k++) name_buf[k] = CH_SPACE;
    base_cnt = 0;
    ext_cnt  = 0;
    seen_cnt = 0;
    lead_dot = 1'b0;
    dot_dot  = 1'b0;
    err_flag = 1'b0;
  endtask

  task take_base_char(input logic [7:0] c);
    if (is_bad(c)) begin
      err_flag = 1'b1;
    end else if (c == CH_DOT) begin
      ph = PH_EXT;
    end else if (base_cnt < BASE_LEN) begin
      name_buf[base_cnt] = to_upper(c);
      base_cnt++;
      if (base_cnt >= BASE_LEN) ph = PH_SKIP;
    end
  endtask

  task format_name_byte(input in_item_t it);
    logic [7:0] c;
    out_item_t  r;
    c = it.name_char;
    if (!err_flag) begin
      if (seen_cnt == 0) begin
        if (c == DEL_MARK) err_flag = 1'b1;
        else if (c == CH_DOT) lead_dot = 1'b1;
        else take_base_char(c);
      end else if (lead_dot) begin
        if (seen_cnt == 1 && c == CH_DOT) dot_dot = 1'b1;
        else err_flag = 1'b1;
      end else if (ph == PH_BASE) begin
        take_base_char(c);
      end else if (ph == PH_SKIP) begin
        if (c == CH_DOT) ph = PH_EXT;
      end else if (ext_cnt < EXT_LEN) begin
        if (is_bad(c) || c == CH_DOT) begin
          err_flag = 1'b1;
        end else begin
          name_buf[BASE_LEN + ext_cnt] = to_upper(c);
          ext_cnt++;
        end
      end
    end
    if (seen_cnt < 3) seen_cnt++;
    if (it.last_char) begin
      if (!err_flag && lead_dot) begin
        name_buf[0] = CH_DOT;
        if (dot_dot) name_buf[1] = CH_DOT;
      end else if (base_cnt == 0) begin
        err_flag = 1'b1;
      end
      if (err_flag) begin
        r.out_char = 8'h00;
        r.status   = 1'b1;
        r.last_out = 1'b1;
        dir_name_q.push_back(r);
        names_bad++;
      end else begin
        for (int k = 0; k < FMT_LEN; k++) begin
          r.out_char = name_buf[k];
          r.status   = 1'b0;
          r.last_out = (k == FMT_LEN - 1);
          dir_name_q.push_back(r);
        end
        names_ok++;
      end
      clear_name_state();
    end
  endtask

  task push_name(input bit hold);
    queued_byte_t e;
    for (int i = 0; i < scratch.size(); i++) begin
      e.item.name_char = scratch[i];
      e.item.last_char = (i == scratch.size() - 1);
      e.hold_idle      = hold && (i == 0);
      name_bytes_q.push_back(e);
    end
  endtask

  task push_str(input string s, input bit hold);
    scratch.delete();
    for (int i = 0; i < s.len(); i++) scratch.push_back(s[i]);
    push_name(hold);
  endtask

  task push_one(input logic [7:0] b);
    scratch.delete();
    scratch.push_back(b);
    push_name(1'b0);
  endtask

  task make_random_name();
    int kind;
    int blen;
    int elen;
    int pos;
    scratch.delete();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      blen = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
      repeat (blen) scratch.push_back(good_char());
      if ($urandom_range(0, 9) < 7) begin
        scratch.push_back(CH_DOT);
        elen = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        repeat (elen) scratch.push_back(good_char());
      end
      if (kind >= 60) begin
        pos = $urandom_range(0, scratch.size() - 1);
        scratch[pos] = bad_char();
      end
    end else if (kind < 88) begin
      scratch.push_back(CH_DOT);
      case ($urandom_range(0, 2))
        0: ;
        1: scratch.push_back(CH_DOT);
        default: repeat ($urandom_range(1, 3)) scratch.push_back(8'($urandom));
      endcase
    end else if (kind < 93) begin
      scratch.push_back(DEL_MARK);
      repeat ($urandom_range(0, 3)) scratch.push_back(good_char());
    end else begin
      repeat ($urandom_range(1, 12)) scratch.push_back(8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      format_name_byte(in_data);
      bytes_in++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (dir_name_q.size() == 0) begin
        fail_cnt++;
        if (mismatches < 10)
          $display("ERROR: unexpected item char=%02h status=%0b last=%0b",
                   out_data.out_char, out_data.status, out_data.last_out);
        mismatches++;
      end else begin
        if (out_data.out_char !== dir_name_q[0].out_char ||
            out_data.status !== dir_name_q[0].status ||
            out_data.last_out !== dir_name_q[0].last_out) begin
          fail_cnt++;
          if (mismatches < 10)
            $display({"ERROR: item %0d exp char=%02h status=%0b last=%0b, ",
                      "got char=%02h status=%0b last=%0b"},
                     results_seen, dir_name_q[0].out_char, dir_name_q[0].status,
                     dir_name_q[0].last_out, out_data.out_char, out_data.status,
                     out_data.last_out);
          mismatches++;
        end
        void'(dir_name_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (name_bytes_q.size() == 0 ||
                   (name_bytes_q[0].hold_idle && dir_name_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= name_bytes_q[0].item;
        in_valid <= 1'b1;
        gap_left <= quiet ? 0 : pick_gap();
        void'(name_bytes_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  initial begin
    clear_name_state();
    push_str(".", 1'b0);
    push_str("..", 1'b1);
    push_str("...", 1'b0);
    push_str(".a", 1'b0);
    push_one(DEL_MARK);
    push_one(8'h00);
    push_one(8'hFF);
    push_str(":", 1'b0);
    push_str("\\", 1'b0);
    push_str("az", 1'b0);
    push_str("x.y.z", 1'b1);
    push_str("A.bcde", 1'b0);
    while (name_bytes_q.size() < 465) begin
      make_random_name();
      push_name($urandom_range(0, 24) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (name_bytes_q.size() != 0 || in_valid || dir_name_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d name bytes: %0d names formatted, %0d rejected.",
             bytes_in, names_ok, names_bad);
    $display("Checked %0d result items, %0d mismatches.", results_seen, mismatches);
    if (fail_cnt == 0 && dir_name_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
